FILE: hw/rtl/olr_pkg.sv
package olr_pkg;

   localparam int COORD_W = 14;
   localparam int COLOR_W = 3;
   localparam int PS_W = 8;
   localparam int GRID_CELLS_DEF = 64;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_PIXEL_SIZE = 1'b0;
   localparam logic [PS_W-1:0] PIXEL_SIZE_RESET = 8'd1;

   localparam int DIV_STEPS = COORD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int NUM_LANES = 4;

   typedef struct packed {
      logic load;
      logic div_step;
      logic setup;
      logic draw;
   } cmd_type;

   typedef struct packed {
      logic last_pixel;
   } status_type;

endpackage

FILE: hw/rtl/olr_ctrl.sv
module olr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output olr_pkg::cmd_type   cmd,
   input  olr_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SETUP,
      ST_DRAW
   } state_type;

   localparam logic [olr_pkg::DIV_CNT_W-1:0] DIV_LAST =
      olr_pkg::DIV_CNT_W'(olr_pkg::DIV_STEPS - 1);

   state_type state_ff, state_in;
   logic [olr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (status.last_pixel) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign cmd.load = (state_ff == ST_IDLE) && start;
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.setup = (state_ff == ST_SETUP);
   assign cmd.draw = (state_ff == ST_DRAW);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && state_ff == ST_DIV))
      else $error("busy not raised after accepted request");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_LAST) |=> (state_ff == ST_SETUP))
      else $error("divide phase length wrong");

   a_draw_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW && status.last_pixel) |=> !busy_ff)
      else $error("busy held after last pixel");

endmodule

FILE: hw/rtl/olr_dp.sv
module olr_dp #(
   parameter int GRID_CELLS = olr_pkg::GRID_CELLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  olr_pkg::cmd_type                  cmd,
   output olr_pkg::status_type               status,
   input  logic [olr_pkg::PS_W-1:0]          pixel_size,
   input  logic [olr_pkg::COORD_W-1:0]       start_x,
   input  logic [olr_pkg::COORD_W-1:0]       start_y,
   input  logic [olr_pkg::COORD_W-1:0]       end_x,
   input  logic [olr_pkg::COORD_W-1:0]       end_y,
   input  logic [olr_pkg::COLOR_W-1:0]       color_in,
   output logic                              strobe,
   output logic [olr_pkg::COORD_W-1:0]       pixel_x,
   output logic [olr_pkg::COORD_W-1:0]       pixel_y,
   output logic [olr_pkg::COLOR_W-1:0]       color_out,
   output logic                              last
);

   localparam int CW = olr_pkg::COORD_W;
   localparam int PW = olr_pkg::PS_W;
   localparam int CELL_W = $clog2(GRID_CELLS);
   localparam int P_W = CELL_W + 3;
   localparam logic [CELL_W-1:0] CELL_MAX = CELL_W'(GRID_CELLS - 1);
   localparam logic [CW-1:0] CELL_MAX_Q = CW'(GRID_CELLS - 1);
   localparam int NL = olr_pkg::NUM_LANES;

   // divider lanes: start x, start y, end x, end y
   logic [CW-1:0] q_ff [NL];
   logic [CW-1:0] q_in [NL];
   logic [PW-1:0] rem_ff [NL];
   logic [PW-1:0] rem_in [NL];
   logic [PW:0] shl [NL];
   logic [CELL_W-1:0] grid_pos [NL];

   logic [PW-1:0] ps_ff;
   logic [olr_pkg::COLOR_W-1:0] color_ff;

   logic [CELL_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CELL_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [CELL_W-1:0] major_ff, major_in, minor_ff, minor_in;
   logic [CELL_W-1:0] cnt_ff;
   logic x_major_ff, x_major_in;
   logic signed [P_W-1:0] p_ff, p_in, p_setup, minor2, diff2;

   logic signed [CELL_W:0] dx, dy;
   logic [CELL_W-1:0] ax, ay;
   logic x_major_s;
   logic [CELL_W-1:0] major_s, minor_s;
   logic pos;
   logic last_pixel;

   logic strobe_ff;
   logic [CW-1:0] pixel_x_ff, pixel_y_ff, pix_x, pix_y;
   logic [olr_pkg::COLOR_W-1:0] color_out_ff;
   logic last_ff;

   // restoring divide, one quotient bit per lane per cycle while div_step is set
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         shl[l] = {rem_ff[l], q_ff[l][CW-1]};
         if (shl[l] >= {1'b0, ps_ff}) begin
            rem_in[l] = PW'(shl[l] - {1'b0, ps_ff});
            q_in[l] = {q_ff[l][CW-2:0], 1'b1};
         end else begin
            rem_in[l] = shl[l][PW-1:0];
            q_in[l] = {q_ff[l][CW-2:0], 1'b0};
         end
         grid_pos[l] = (q_ff[l] > CELL_MAX_Q) ? CELL_MAX : q_ff[l][CELL_W-1:0];
      end
   end

   // octant setup
   always_comb begin
      dx = $signed({1'b0, grid_pos[2]}) - $signed({1'b0, grid_pos[0]});
      dy = $signed({1'b0, grid_pos[3]}) - $signed({1'b0, grid_pos[1]});
      ax = (dx < 0) ? CELL_W'(-dx) : dx[CELL_W-1:0];
      ay = (dy < 0) ? CELL_W'(-dy) : dy[CELL_W-1:0];
      sx_in = (dx > 0) ? CELL_W'(1) : ((dx < 0) ? '1 : '0);
      sy_in = (dy > 0) ? CELL_W'(1) : ((dy < 0) ? '1 : '0);
      x_major_s = (ax >= ay);
      major_s = x_major_s ? ax : ay;
      minor_s = x_major_s ? ay : ax;
      p_setup = $signed({2'b00, minor_s, 1'b0}) - $signed({3'b000, major_s});
   end

   // decision step
   always_comb begin
      pos = (p_ff > 0);
      minor2 = $signed({2'b00, minor_ff, 1'b0});
      diff2 = minor2 - $signed({2'b00, major_ff, 1'b0});
      p_in = pos ? (p_ff + diff2) : (p_ff + minor2);
      if (x_major_ff) begin
         cur_x_in = cur_x_ff + sx_ff;
         cur_y_in = pos ? (cur_y_ff + sy_ff) : cur_y_ff;
      end else begin
         cur_y_in = cur_y_ff + sy_ff;
         cur_x_in = pos ? (cur_x_ff + sx_ff) : cur_x_ff;
      end
      last_pixel = (cnt_ff == major_ff);
      pix_x = CW'(cur_x_ff) * CW'(ps_ff);
      pix_y = CW'(cur_y_ff) * CW'(ps_ff);
   end

   assign major_in = major_s;
   assign minor_in = minor_s;
   assign x_major_in = x_major_s;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff[0] <= start_x;
         q_ff[1] <= start_y;
         q_ff[2] <= end_x;
         q_ff[3] <= end_y;
         for (int l = 0; l < NL; l++) begin
            rem_ff[l] <= '0;
         end
         ps_ff <= (pixel_size == '0) ? PW'(1) : pixel_size;
         color_ff <= color_in;
      end else if (cmd.div_step) begin
         for (int l = 0; l < NL; l++) begin
            q_ff[l] <= q_in[l];
            rem_ff[l] <= rem_in[l];
         end
      end
      if (cmd.setup) begin
         cur_x_ff <= grid_pos[0];
         cur_y_ff <= grid_pos[1];
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         x_major_ff <= x_major_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         p_ff <= p_setup;
         cnt_ff <= '0;
      end else if (cmd.draw) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         p_ff <= p_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.draw) begin
         pixel_x_ff <= pix_x;
         pixel_y_ff <= pix_y;
         color_out_ff <= color_ff;
         last_ff <= last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.draw;
      end
   end

   assign status.last_pixel = last_pixel;
   assign strobe = strobe_ff;
   assign pixel_x = pixel_x_ff;
   assign pixel_y = pixel_y_ff;
   assign color_out = color_out_ff;
   assign last = last_ff;

endmodule

FILE: hw/rtl/octant_line_rasterizer.sv
// Draws one line per request on a coarse grid: both endpoints are divided by
// pixel_size (a value of 0 acts as 1), cells beyond the grid are clamped, and
// a Bresenham stepper emits one pixel per cycle from the start cell to the end
// cell. A request taken with start while busy is low keeps busy high through
// the bit-serial endpoint dividers, the setup step and the stepper, which emits
// N pixels, N being the pixel count (|major delta| + 1, at most GRID_CELLS).
// Pixels come out on consecutive cycles, each marked by rsp_strobe for one
// cycle, the final one with rsp_last; the receiver cannot stall them. Program
// pixel_size only while busy is low and no pixel is pending.
module octant_line_rasterizer #(
   parameter int GRID_CELLS = olr_pkg::GRID_CELLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [olr_pkg::COORD_W-1:0]         req_start_x,
   input  logic [olr_pkg::COORD_W-1:0]         req_start_y,
   input  logic [olr_pkg::COORD_W-1:0]         req_end_x,
   input  logic [olr_pkg::COORD_W-1:0]         req_end_y,
   input  logic [olr_pkg::COLOR_W-1:0]         req_color_in,
   output logic                                rsp_strobe,
   output logic [olr_pkg::COORD_W-1:0]         rsp_pixel_x,
   output logic [olr_pkg::COORD_W-1:0]         rsp_pixel_y,
   output logic [olr_pkg::COLOR_W-1:0]         rsp_color_out,
   output logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [olr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [olr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [olr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   logic [olr_pkg::PS_W-1:0] pixel_size_ff, pixel_size_in;
   logic [olr_pkg::REG_IDX_W-1:0] reg_idx;
   logic wr_en;
   olr_pkg::cmd_type cmd;
   olr_pkg::status_type status;

   // register file
   assign reg_idx = paddr[olr_pkg::CSR_ADDR_W-1:2];
   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite && pready
                  && (reg_idx == olr_pkg::REG_PIXEL_SIZE);
   assign pixel_size_in = wr_en ? pwdata[olr_pkg::PS_W-1:0] : pixel_size_ff;
   assign prdata = (reg_idx == olr_pkg::REG_PIXEL_SIZE)
                   ? olr_pkg::CSR_DATA_W'(pixel_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_size_ff <= olr_pkg::PIXEL_SIZE_RESET;
      end else begin
         pixel_size_ff <= pixel_size_in;
      end
   end

   olr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   olr_dp #(
      .GRID_CELLS (GRID_CELLS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pixel_size (pixel_size_ff),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .color_in   (req_color_in),
      .strobe     (rsp_strobe),
      .pixel_x    (rsp_pixel_x),
      .pixel_y    (rsp_pixel_y),
      .color_out  (rsp_color_out),
      .last       (rsp_last)
   );

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("transfer right after last pixel");

endmodule

FILE: tb/line_checker.sv
`timescale 1ns / 100ps

module line_checker #(
   parameter int GRID_CELLS = olr_pkg::GRID_CELLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [olr_pkg::COORD_W-1:0]    req_start_x,
   input  logic [olr_pkg::COORD_W-1:0]    req_start_y,
   input  logic [olr_pkg::COORD_W-1:0]    req_end_x,
   input  logic [olr_pkg::COORD_W-1:0]    req_end_y,
   input  logic [olr_pkg::COLOR_W-1:0]    req_color_in,
   input  logic                           rsp_strobe,
   input  logic [olr_pkg::COORD_W-1:0]    rsp_pixel_x,
   input  logic [olr_pkg::COORD_W-1:0]    rsp_pixel_y,
   input  logic [olr_pkg::COLOR_W-1:0]    rsp_color_out,
   input  logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [olr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [olr_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           pready,
   output int                             fail_count,
   output int                             pending
);

   typedef struct packed {
      logic [olr_pkg::COORD_W-1:0] x;
      logic [olr_pkg::COORD_W-1:0] y;
      logic [olr_pkg::COLOR_W-1:0] color;
      logic                        last;
   } pixel_type;

   pixel_type                expected_pixels[$];
   logic [olr_pkg::PS_W-1:0] pixel_size_q;
   int                       mismatches;

   function automatic int cell_of(logic [olr_pkg::COORD_W-1:0] coord, int ps);
      int c;
      c = int'(coord) / ps;
      if (c > GRID_CELLS - 1) c = GRID_CELLS - 1;
      return c;
   endfunction

   function automatic logic [olr_pkg::COORD_W-1:0] to_screen(int grid_pos, int ps);
      logic [31:0] scaled;
      scaled = grid_pos * ps;
      return scaled[olr_pkg::COORD_W-1:0];
   endfunction

   function automatic void predict_line(logic [olr_pkg::COORD_W-1:0] sx,
                                        logic [olr_pkg::COORD_W-1:0] sy,
                                        logic [olr_pkg::COORD_W-1:0] ex,
                                        logic [olr_pkg::COORD_W-1:0] ey,
                                        logic [olr_pkg::COLOR_W-1:0] color);
      int        ps, x, y, x1, y1, dx, dy, step_x, step_y, ax, ay, major, minor, decision;
      bit        x_major;
      pixel_type px;
      ps = (pixel_size_q == 0) ? 1 : int'(pixel_size_q);
      x = cell_of(sx, ps);
      y = cell_of(sy, ps);
      x1 = cell_of(ex, ps);
      y1 = cell_of(ey, ps);
      dx = x1 - x;
      dy = y1 - y;
      step_x = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      step_y = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      x_major = (ax >= ay);
      major = x_major ? ax : ay;
      minor = x_major ? ay : ax;
      decision = 2 * minor - major;
      for (int i = 0; i <= major && i < GRID_CELLS; i++) begin
         if (i > 0) begin
            if (decision > 0) begin
               if (x_major) y += step_y;
               else x += step_x;
               decision += 2 * (minor - major);
            end else begin
               decision += 2 * minor;
            end
            if (x_major) x += step_x;
            else y += step_y;
         end
         px.x = to_screen(x, ps);
         px.y = to_screen(y, ps);
         px.color = color;
         px.last = (i == major);
         expected_pixels = {expected_pixels, px};
      end
   endfunction

   always @(posedge clock) begin
      pixel_type exp_px;
      if (reset) begin
         expected_pixels.delete();
         pixel_size_q = olr_pkg::PIXEL_SIZE_RESET;
      end else begin
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0b", $realtime,
                           rsp_pixel_x, rsp_pixel_y, rsp_color_out, rsp_last);
               mismatches++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_pixel_x !== exp_px.x || rsp_pixel_y !== exp_px.y ||
                   rsp_color_out !== exp_px.color || rsp_last !== exp_px.last) begin
                  if (mismatches < 10)
                     $display({"%0t: pixel mismatch exp x=%0d y=%0d color=%0d last=%0b,",
                               " got x=%0d y=%0d color=%0d last=%0b"},
                              $realtime, exp_px.x, exp_px.y, exp_px.color, exp_px.last,
                              rsp_pixel_x, rsp_pixel_y, rsp_color_out, rsp_last);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            predict_line(req_start_x, req_start_y, req_end_x, req_end_y, req_color_in);
         if (psel && penable && pwrite && pready &&
             paddr[olr_pkg::CSR_ADDR_W-1:2] == olr_pkg::REG_PIXEL_SIZE)
            pixel_size_q = pwdata[olr_pkg::PS_W-1:0];
      end
      fail_count <= mismatches;
      pending <= expected_pixels.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int GRID = olr_pkg::GRID_CELLS_DEF;
   localparam int COORD_MAX = (1 << olr_pkg::COORD_W) - 1;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [olr_pkg::COORD_W-1:0]    req_start_x, req_start_y, req_end_x, req_end_y;
   logic [olr_pkg::COLOR_W-1:0]    req_color_in;
   logic                           rsp_strobe;
   logic [olr_pkg::COORD_W-1:0]    rsp_pixel_x, rsp_pixel_y;
   logic [olr_pkg::COLOR_W-1:0]    rsp_color_out;
   logic                           rsp_last;
   logic                           psel, penable, pwrite;
   logic [olr_pkg::CSR_ADDR_W-1:0] paddr;
   logic [olr_pkg::CSR_DATA_W-1:0] pwdata;
   logic [olr_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;
   int                             fail_count;
   int                             pending;
   bit                             quiet;
   int                             cur_ps;

   octant_line_rasterizer #(.GRID_CELLS(GRID)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_color_in(req_color_in),
      .rsp_strobe(rsp_strobe), .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_color_out(rsp_color_out), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   line_checker #(.GRID_CELLS(GRID)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_color_in(req_color_in),
      .rsp_strobe(rsp_strobe), .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_color_out(rsp_color_out), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                            input int color);
      int gap;
      if (!quiet && $urandom_range(99) < 19) begin
         start <= 1'b0;
         gap = $urandom_range(1, 30);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_start_x <= sx[olr_pkg::COORD_W-1:0];
      req_start_y <= sy[olr_pkg::COORD_W-1:0];
      req_end_x <= ex[olr_pkg::COORD_W-1:0];
      req_end_y <= ey[olr_pkg::COORD_W-1:0];
      req_color_in <= color[olr_pkg::COLOR_W-1:0];
      do @(posedge clock); while (busy);
   endtask

   task automatic drain(input int extra);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(input logic [olr_pkg::PS_W-1:0] value);
      logic [olr_pkg::CSR_DATA_W-1:0] word;
      word = $urandom();
      word[olr_pkg::PS_W-1:0] = value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {olr_pkg::REG_PIXEL_SIZE, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cur_ps = (value == 0) ? 1 : int'(value);
   endtask

   function automatic int rand_coord();
      int hi;
      hi = cur_ps * (GRID + 2);
      if (hi > COORD_MAX) hi = COORD_MAX;
      if ($urandom_range(99) < 15) return $urandom_range(COORD_MAX);
      return $urandom_range(hi);
   endfunction

   task automatic random_lines(input int count);
      int sx, sy, ex, ey;
      send_line(COORD_MAX, 0, 0, COORD_MAX, 7);
      send_line(0, COORD_MAX, COORD_MAX, 0, 0);
      for (int n = 0; n < count; n++) begin
         sx = rand_coord();
         sy = rand_coord();
         ex = rand_coord();
         ey = rand_coord();
         if ($urandom_range(99) < 6) begin
            ex = sx;
            ey = sy;
         end
         send_line(sx, sy, ex, ey, $urandom_range(7));
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_start_x <= '0;
      req_start_y <= '0;
      req_end_x <= '0;
      req_end_y <= '0;
      req_color_in <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      quiet = 1'b0;
      cur_ps = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero length, clamping, axis lines, diagonals and all octants
      send_line(0, 0, 0, 0, 0);
      send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 7);
      send_line(0, 0, 63, 0, 1);
      send_line(63, 0, 0, 0, 2);
      send_line(0, 0, 0, 63, 3);
      send_line(0, 63, 0, 0, 4);
      send_line(0, 0, 63, 63, 5);
      send_line(63, 63, 0, 0, 6);
      send_line(0, 63, 63, 0, 7);
      send_line(63, 0, 0, 63, 0);
      send_line(10, 10, 30, 15, 1);
      send_line(30, 15, 10, 10, 2);
      send_line(10, 10, 15, 30, 3);
      send_line(15, 30, 10, 10, 4);
      send_line(10, 10, 30, 5, 5);
      send_line(30, 5, 10, 10, 6);
      send_line(10, 10, 5, 30, 7);
      send_line(5, 30, 10, 10, 0);
      send_line(100, 200, 5, COORD_MAX, 3);
      send_line(COORD_MAX, 7, 64, 40, 6);

      random_lines(40);
      drain(8);
      csr_write(8'd255);
      random_lines(40);
      drain(8);
      csr_write(8'd0);
      random_lines(40);
      quiet = 1'b1;
      drain(8);
      csr_write(8'd128);
      random_lines(40);
      drain(8);
      csr_write(8'd3);
      random_lines(40);
      quiet = 1'b0;
      drain(8);
      csr_write(8'($urandom_range(2, 254)));
      random_lines(40);
      drain(8);
      csr_write(8'd1);
      random_lines(20);

      drain(80);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
